FILE: design/ftat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftat_pkg: shared types and constants of the front tire aligning torque unit
// Item structs, configuration layout and indexes, arctangent table and the
// fixed-point constants used by the datapath.
// ----------------------------------------------------------------------------
package ftat_pkg;

  localparam int CORDIC_STEPS_DEF = 18;
  localparam int TBL_LEN          = 24;
  localparam int U_FRAC           = 24;

  localparam logic signed [47:0] VX_OFFSET_Q32 = 48'sd1717986918;
  localparam logic signed [17:0] VX_LOW_Q10    = 18'sd102;
  localparam logic [16:0]        HALF_PI_Q16   = 17'd102944;
  localparam logic [28:0]        RECIP_135     = 29'd509033162;
  localparam logic [19:0]        RECIP_3       = 20'd699051;
  localparam logic [23:0]        RECIP_10      = 24'd13421773;

  typedef enum logic [2:0] {
    CFG_INITIAL_TRAIL       = 3'd0,
    CFG_CORNERING_STIFFNESS = 3'd1,
    CFG_NORMAL_LOAD         = 3'd2,
    CFG_MECHANICAL_TRAIL    = 3'd3,
    CFG_FRONT_AXLE_DISTANCE = 3'd4
  } ftat_cfg_idx_t;

  typedef struct packed {
    logic [15:0] initial_trail;
    logic [19:0] cornering_stiffness;
    logic [14:0] normal_load;
    logic [15:0] mechanical_trail;
    logic [18:0] front_axle_distance;
  } ftat_cfg_t;

  localparam ftat_cfg_t CFG_RESET = '{
    initial_trail:       16'd2621,
    cornering_stiffness: 20'd110000,
    normal_load:         15'd4000,
    mechanical_trail:    16'd0,
    front_axle_distance: 19'd88474
  };

  typedef struct packed {
    logic [17:0] steer_angle;
    logic [17:0] long_speed;
    logic [19:0] yaw_rate;
    logic [17:0] lat_speed;
  } ftat_in_t;

  typedef struct packed {
    logic [23:0] aligning_torque;
    logic [15:0] pneumatic_trail;
    logic [23:0] lateral_force;
    logic [16:0] slide_angle;
    logic [18:0] slip_angle;
  } ftat_out_t;

  typedef struct packed {
    logic [47:0] num;
    logic [47:0] den;
    logic        low_speed;
    logic [17:0] delta;
  } ftat_mid_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'd843314857;
      1:       v = 32'd497837829;
      2:       v = 32'd263043837;
      3:       v = 32'd133525159;
      4:       v = 32'd67021687;
      5:       v = 32'd33543516;
      6:       v = 32'd16775851;
      7:       v = 32'd8388437;
      8:       v = 32'd4194283;
      9:       v = 32'd2097149;
      10:      v = 32'd1048576;
      11:      v = 32'd524288;
      12:      v = 32'd262144;
      13:      v = 32'd131072;
      14:      v = 32'd65536;
      15:      v = 32'd32768;
      16:      v = 32'd16384;
      17:      v = 32'd8192;
      18:      v = 32'd4096;
      19:      v = 32'd2048;
      20:      v = 32'd1024;
      21:      v = 32'd512;
      22:      v = 32'd256;
      23:      v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: design/ftat_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftat_queue: small first-in first-out buffer
// Register-based queue with full and empty flags; a write and a read may
// share one cycle.
// ----------------------------------------------------------------------------
module ftat_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/ftat_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftat_front: input classification and arctangent operand setup
// Flags the low-speed case and forms the slip arctangent operands with the
// denominator made non-negative.
// ----------------------------------------------------------------------------
module ftat_front (
  input  ftat_pkg::ftat_in_t  in_item,
  input  ftat_pkg::ftat_cfg_t cfg,
  output ftat_pkg::ftat_mid_t mid_item
);
  import ftat_pkg::*;

  logic signed [17:0] vx_s, vy_s;
  logic signed [19:0] r_s, a_s;
  logic signed [39:0] ar;
  logic signed [47:0] vx48, vy48, num48, den48;
  logic               neg;

  assign vx_s  = $signed(in_item.long_speed);
  assign vy_s  = $signed(in_item.lat_speed);
  assign r_s   = $signed(in_item.yaw_rate);
  assign a_s   = $signed({1'b0, cfg.front_axle_distance});
  assign ar    = a_s * r_s;
  assign vx48  = 48'(vx_s);
  assign vy48  = 48'(vy_s);
  assign num48 = (vy48 <<< 22) + 48'(ar);
  assign den48 = (vx48 <<< 22) + VX_OFFSET_Q32;
  assign neg   = den48[47];

  always_comb begin
    mid_item.num       = neg ? -num48 : num48;
    mid_item.den       = neg ? -den48 : den48;
    mid_item.low_speed = !((vx_s > VX_LOW_Q10) || (vx_s < -VX_LOW_Q10));
    mid_item.delta     = in_item.steer_angle;
  end
endmodule
`default_nettype wire

FILE: design/ftat_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftat_cordic: pipelined CORDIC, one iteration per stage
// Vectoring mode accumulates the arctangent; rotation mode drives the angle
// to zero and leaves gain-scaled cosine and sine on x and y.
// ----------------------------------------------------------------------------
module ftat_cordic #(
  parameter int STEPS  = ftat_pkg::CORDIC_STEPS_DEF,
  parameter int W      = 48,
  parameter int ZW     = 36,
  parameter bit ROTATE = 1'b0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o
);
  import ftat_pkg::*;

  logic signed [W-1:0]  x_r [STEPS];
  logic signed [W-1:0]  y_r [STEPS];
  logic signed [ZW-1:0] z_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic signed [W-1:0]  xa, ya, xs, ys;
    logic signed [ZW-1:0] za, at;
    logic                 up;
    if (k == 0) begin : g_first
      assign xa = x_i;
      assign ya = y_i;
      assign za = z_i;
    end else begin : g_next
      assign xa = x_r[k-1];
      assign ya = y_r[k-1];
      assign za = z_r[k-1];
    end
    assign xs = xa >>> k;
    assign ys = ya >>> k;
    assign at = $signed({{(ZW - 32){1'b0}}, atan_q30(k)});
    assign up = ROTATE ? za[ZW-1] : !ya[W-1];
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= up ? xa + ys : xa - ys;
        y_r[k] <= up ? ya - xs : ya + xs;
        z_r[k] <= up ? za + at : za - at;
      end
    end
  end

  assign x_o = x_r[STEPS-1];
  assign y_o = y_r[STEPS-1];
  assign z_o = z_r[STEPS-1];
endmodule
`default_nettype wire

FILE: design/ftat_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftat_back: slip, sliding angle, trail, lateral force and torque pipeline
// Two arctangent pipelines, a rotation pipeline for sine and cosine, a
// radix-2 divider and the force polynomial; the whole pipe holds on a stall.
// ----------------------------------------------------------------------------
module ftat_back #(
  parameter int STEPS = ftat_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ftat_pkg::ftat_cfg_t cfg,
  input  ftat_pkg::ftat_mid_t mid_item,
  input  logic                mid_valid,
  output logic                mid_pop,
  input  logic                res_full,
  output logic                res_wr,
  output ftat_pkg::ftat_out_t res_item
);
  import ftat_pkg::*;

  localparam int VW    = 48;
  localparam int ZW    = 36;
  localparam int RW    = 34;
  localparam int DIV_N = U_FRAC + 2;
  localparam logic [25:0] THREE = 26'(3) << U_FRAC;
  localparam logic signed [RW-1:0] ONE_Q30 = RW'(1) << 30;

  typedef struct packed {
    logic [18:0] slip;
    logic [16:0] slide;
    logic        lin;
    logic        zero;
  } side_t;

  function automatic logic signed [21:0] q30_to_q16(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = z + ZW'(8192);
    return 22'(t >>> 14);
  endfunction

  logic en;
  assign en      = !res_full;
  assign mid_pop = en && mid_valid;

  logic [23:0] cf10;
  logic [20:0] fz42;
  logic [18:0] fz14;
  logic [22:0] fz224, fz224r;
  logic [47:0] fsat_p;
  logic [19:0] fsat;
  logic signed [VW-1:0] sl_x, sl_y;

  assign cf10   = 24'(cfg.cornering_stiffness) * 24'd10;
  assign fz42   = 21'(cfg.normal_load) * 21'd42;
  assign fz14   = 19'(cfg.normal_load) * 19'd14;
  assign fz224  = 23'(cfg.normal_load) * 23'd224;
  assign fz224r = fz224 + 23'd5;
  assign fsat_p = 48'(fz224r) * 48'(RECIP_10);
  assign fsat   = 20'(fsat_p >> 27);
  assign sl_x   = $signed({8'b0, cf10, 16'b0});
  assign sl_y   = $signed({11'b0, fz42, 16'b0});

  logic signed [ZW-1:0] za_slip, za_slide;

  ftat_cordic #(.STEPS(STEPS), .W(VW), .ZW(ZW), .ROTATE(1'b0)) u_atan_slip (
    .clk (clk), .en (en),
    .x_i ($signed(mid_item.den)), .y_i ($signed(mid_item.num)), .z_i ('0),
    .x_o (), .y_o (), .z_o (za_slip)
  );

  ftat_cordic #(.STEPS(STEPS), .W(VW), .ZW(ZW), .ROTATE(1'b0)) u_atan_slide (
    .clk (clk), .en (en),
    .x_i (sl_x), .y_i (sl_y), .z_i ('0),
    .x_o (), .y_o (), .z_o (za_slide)
  );

  logic        va_r [STEPS];
  logic [17:0] da_r [STEPS];
  logic        la_r [STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STEPS; k++) va_r[k] <= 1'b0;
    end else if (en) begin
      va_r[0] <= mid_valid;
      da_r[0] <= mid_item.delta;
      la_r[0] <= mid_item.low_speed;
      for (int k = 1; k < STEPS; k++) begin
        va_r[k] <= va_r[k-1];
        da_r[k] <= da_r[k-1];
        la_r[k] <= la_r[k-1];
      end
    end
  end

  logic signed [21:0] slip_q, slide_q;
  logic signed [22:0] slip_w;
  logic [18:0]        slip_nxt;
  logic [16:0]        slide_nxt;
  logic               p1_v_r;
  logic [18:0]        p1_slip_r;
  logic [16:0]        p1_slide_r;

  always_comb begin
    slip_q  = q30_to_q16(za_slip);
    slide_q = q30_to_q16(za_slide);
    slip_w  = 23'($signed(da_r[STEPS-1])) - 23'(slip_q);
    if (la_r[STEPS-1]) begin
      slip_nxt = '0;
    end else if (slip_w > 23'sd262143) begin
      slip_nxt = 19'h3FFFF;
    end else if (slip_w < -23'sd262144) begin
      slip_nxt = 19'h40000;
    end else begin
      slip_nxt = slip_w[18:0];
    end
    if (cfg.normal_load == '0 || slide_q < 0) begin
      slide_nxt = '0;
    end else if (slide_q > $signed({5'b0, HALF_PI_Q16})) begin
      slide_nxt = HALF_PI_Q16;
    end else begin
      slide_nxt = slide_q[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r     <= va_r[STEPS-1];
      p1_slip_r  <= slip_nxt;
      p1_slide_r <= slide_nxt;
    end
  end

  logic [18:0]          mag1;
  logic signed [ZW-1:0] z_rot;
  logic signed [RW-1:0] c_rot, s_rot;
  side_t                side1;

  assign mag1 = p1_slip_r[18] ? 19'(-p1_slip_r) : p1_slip_r;
  assign z_rot = $signed({3'b0, mag1, 14'b0});
  assign side1 = '{slip: p1_slip_r, slide: p1_slide_r,
                   lin: (mag1 < {2'b0, p1_slide_r}), zero: (mag1 == '0)};

  ftat_cordic #(.STEPS(STEPS), .W(RW), .ZW(ZW), .ROTATE(1'b1)) u_rot (
    .clk (clk), .en (en),
    .x_i (ONE_Q30), .y_i ('0), .z_i (z_rot),
    .x_o (c_rot), .y_o (s_rot), .z_o ()
  );

  logic  vb_r [STEPS];
  side_t sb_r [STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STEPS; k++) vb_r[k] <= 1'b0;
    end else if (en) begin
      vb_r[0] <= p1_v_r;
      sb_r[0] <= side1;
      for (int k = 1; k < STEPS; k++) begin
        vb_r[k] <= vb_r[k-1];
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  logic signed [RW-1:0] s_abs;
  logic        p3_v_r, p3_cneg_r;
  logic [55:0] p3_n_r;
  logic [50:0] p3_d_r;
  side_t       p3_side_r;

  assign s_abs = s_rot[RW-1] ? -s_rot : s_rot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r    <= vb_r[STEPS-1];
      p3_n_r    <= 56'(cf10) * 56'(s_abs[31:0]);
      p3_d_r    <= 51'(fz14) * 51'(c_rot[31:0]);
      p3_cneg_r <= c_rot[RW-1] || (c_rot == '0);
      p3_side_r <= sb_r[STEPS-1];
    end
  end

  logic [52:0] d3;
  logic        p4_v_r, p4_sat_r;
  logic [55:0] p4_n_r;
  logic [50:0] p4_d_r;
  side_t       p4_side_r;

  assign d3 = {1'b0, p3_d_r, 1'b0} + 53'(p3_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else if (en) begin
      p4_v_r    <= p3_v_r;
      p4_n_r    <= p3_n_r;
      p4_d_r    <= p3_d_r;
      p4_sat_r  <= p3_cneg_r || (p3_n_r >= 56'(d3));
      p4_side_r <= p3_side_r;
    end
  end

  logic        dv_v_r    [DIV_N];
  logic        dv_sat_r  [DIV_N];
  logic [55:0] dv_rem_r  [DIV_N];
  logic [50:0] dv_d_r    [DIV_N];
  logic [25:0] dv_q_r    [DIV_N];
  side_t       dv_side_r [DIV_N];

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    logic [55:0] rem_in, cand, rem_sh;
    logic [50:0] d_in;
    logic [25:0] q_in;
    logic        v_in, sat_in, take;
    side_t       side_in;
    if (j == 0) begin : g_first
      assign rem_in  = p4_n_r;
      assign d_in    = p4_d_r;
      assign q_in    = '0;
      assign v_in    = p4_v_r;
      assign sat_in  = p4_sat_r;
      assign side_in = p4_side_r;
    end else begin : g_next
      assign rem_in  = dv_rem_r[j-1];
      assign d_in    = dv_d_r[j-1];
      assign q_in    = dv_q_r[j-1];
      assign v_in    = dv_v_r[j-1];
      assign sat_in  = dv_sat_r[j-1];
      assign side_in = dv_side_r[j-1];
    end
    if (j == 0) begin : g_bit1
      assign rem_sh = rem_in;
      assign cand   = {4'b0, d_in, 1'b0};
    end else if (j == 1) begin : g_bit0
      assign rem_sh = rem_in;
      assign cand   = 56'(d_in);
    end else begin : g_frac
      assign rem_sh = {rem_in[54:0], 1'b0};
      assign cand   = 56'(d_in);
    end
    assign take = (rem_sh >= cand);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j]    <= v_in;
        dv_sat_r[j]  <= sat_in;
        dv_rem_r[j]  <= take ? rem_sh - cand : rem_sh;
        dv_d_r[j]    <= d_in;
        dv_q_r[j]    <= {q_in[24:0], take};
        dv_side_r[j] <= side_in;
      end
    end
  end

  logic        pm_v_r;
  logic [25:0] pm_m_r;
  side_t       pm_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r <= 1'b0;
    end else if (en) begin
      pm_v_r    <= dv_v_r[DIV_N-1];
      pm_m_r    <= dv_side_r[DIV_N-1].zero ? '0 :
                   (dv_sat_r[DIV_N-1] ? THREE : dv_q_r[DIV_N-1]);
      pm_side_r <= dv_side_r[DIV_N-1];
    end
  end

  logic [51:0] m2p;
  logic        p6_v_r;
  logic [25:0] p6_m_r;
  logic [27:0] p6_m2_r;
  logic [41:0] p6_tp_r;
  side_t       p6_side_r;

  assign m2p = 52'(pm_m_r) * 52'(pm_m_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_v_r <= 1'b0;
    end else if (en) begin
      p6_v_r    <= pm_v_r;
      p6_m_r    <= pm_m_r;
      p6_m2_r   <= m2p[51:24];
      p6_tp_r   <= 42'(cfg.initial_trail) * 42'(pm_m_r);
      p6_side_r <= pm_side_r;
    end
  end

  logic [53:0] m3p;
  logic [42:0] tpy_s;
  logic        p7_v_r;
  logic [25:0] p7_m_r;
  logic [27:0] p7_m2_r;
  logic [29:0] p7_m3_r;
  logic [39:0] p7_tpk_r;
  side_t       p7_side_r;

  assign m3p   = 54'(p6_m2_r) * 54'(p6_m_r);
  assign tpy_s = 43'(p6_tp_r) + (43'(3) << 23);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_v_r <= 1'b0;
    end else if (en) begin
      p7_v_r    <= p6_v_r;
      p7_m_r    <= p6_m_r;
      p7_m2_r   <= p6_m2_r;
      p7_m3_r   <= m3p[53:24];
      p7_tpk_r  <= 40'(tpy_s[42:24]) * 40'(RECIP_3);
      p7_side_r <= p6_side_r;
    end
  end

  logic signed [34:0] gs;
  logic [15:0]        tp_sub;
  logic               p8_v_r;
  logic [29:0]        p8_g_r;
  logic [15:0]        p8_tp_r;
  side_t              p8_side_r;

  assign gs = $signed(35'(p7_m_r) * 35'd27) - $signed(35'(p7_m2_r) * 35'd9)
              + $signed(35'(p7_m3_r));
  assign tp_sub = 16'(p7_tpk_r >> 21);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p8_v_r <= 1'b0;
    end else if (en) begin
      p8_v_r    <= p7_v_r;
      p8_g_r    <= gs[34] ? '0 : gs[29:0];
      p8_tp_r   <= cfg.initial_trail - tp_sub;
      p8_side_r <= p7_side_r;
    end
  end

  logic        p9_v_r;
  logic [52:0] p9_fx_r;
  logic [15:0] p9_tp_r;
  side_t       p9_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p9_v_r <= 1'b0;
    end else if (en) begin
      p9_v_r    <= p8_v_r;
      p9_fx_r   <= 53'(fz224) * 53'(p8_g_r);
      p9_tp_r   <= p8_tp_r;
      p9_side_r <= p8_side_r;
    end
  end

  logic [53:0] fy_s;
  logic        p10_v_r;
  logic [57:0] p10_fk_r;
  logic [15:0] p10_tp_r;
  side_t       p10_side_r;

  assign fy_s = 54'(p9_fx_r) + (54'(135) << 24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p10_v_r <= 1'b0;
    end else if (en) begin
      p10_v_r    <= p9_v_r;
      p10_fk_r   <= 58'(fy_s[53:25]) * 58'(RECIP_135);
      p10_tp_r   <= p9_tp_r;
      p10_side_r <= p9_side_r;
    end
  end

  logic        p11_v_r;
  logic [19:0] p11_fmag_r;
  logic [15:0] p11_tp_r;
  side_t       p11_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p11_v_r <= 1'b0;
    end else if (en) begin
      p11_v_r    <= p10_v_r;
      p11_fmag_r <= p10_side_r.lin ? 20'(p10_fk_r >> 36) :
                    ((p10_side_r.slip == '0) ? '0 : fsat);
      p11_tp_r   <= p10_side_r.lin ? p10_tp_r : '0;
      p11_side_r <= p10_side_r;
    end
  end

  logic [16:0] tsum;
  logic        p12_v_r;
  logic [36:0] p12_prod_r;
  logic [19:0] p12_fmag_r;
  logic [15:0] p12_tp_r;
  side_t       p12_side_r;

  assign tsum = 17'(cfg.mechanical_trail) + 17'(p11_tp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p12_v_r <= 1'b0;
    end else if (en) begin
      p12_v_r    <= p11_v_r;
      p12_prod_r <= 37'(tsum) * 37'(p11_fmag_r);
      p12_fmag_r <= p11_fmag_r;
      p12_tp_r   <= p11_tp_r;
      p12_side_r <= p11_side_r;
    end
  end

  logic [37:0] tmag_s;
  logic [21:0] tmag;
  logic        slip_pos, slip_neg;

  assign tmag_s   = 38'(p12_prod_r) + 38'd32768;
  assign tmag     = tmag_s[37:16];
  assign slip_neg = p12_side_r.slip[18];
  assign slip_pos = !slip_neg && (p12_side_r.slip != '0);
  assign res_wr   = en && p12_v_r;

  always_comb begin
    res_item.aligning_torque = slip_neg ? -24'(tmag) : 24'(tmag);
    res_item.pneumatic_trail = p12_tp_r;
    res_item.lateral_force   = slip_pos ? -24'(p12_fmag_r) : 24'(p12_fmag_r);
    res_item.slide_angle     = p12_side_r.slide;
    res_item.slip_angle      = p12_side_r.slip;
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> !res_full) else $error("result written into a full queue");

  a_last_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (en && p11_v_r) |=> p12_v_r) else $error("item lost before the last stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && p12_v_r) |=> (p12_v_r && $stable(p12_prod_r)))
    else $error("last stage changed during a stall");

  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pm_v_r |-> (pm_m_r <= THREE)) else $error("slip ratio above three");
endmodule
`default_nettype wire

FILE: design/front_tire_aligning_torque.sv
`default_nettype none
// ----------------------------------------------------------------------------
// front_tire_aligning_torque: front slip, lateral force and aligning torque
// Brush tire model in fixed point: slip angle, sliding angle, pneumatic
// trail, saturating lateral force and aligning torque per input item.
// ----------------------------------------------------------------------------
// Datapath: two CORDIC passes and a 26-step divider in series between the
// input transfer and the shown result. Throughput: one item per cycle while
// the output queue is not full, one result per item.
// Reset clears both queues and all stage valid bits and loads the
// configuration registers with their default values.
module front_tire_aligning_torque #(
  parameter int CORDIC_STEPS = ftat_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  ftat_pkg::ftat_in_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output ftat_pkg::ftat_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [19:0]         cfg_data
);
  import ftat_pkg::*;

  ftat_cfg_t cfg_r;
  ftat_mid_t mid_wr_item, mid_rd_item;
  ftat_out_t res_item;
  logic      mid_full, mid_empty, mid_pop, mid_wr, res_wr, res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INITIAL_TRAIL:       cfg_r.initial_trail       <= cfg_data[15:0];
        CFG_CORNERING_STIFFNESS: cfg_r.cornering_stiffness <= cfg_data;
        CFG_NORMAL_LOAD:         cfg_r.normal_load         <= cfg_data[14:0];
        CFG_MECHANICAL_TRAIL:    cfg_r.mechanical_trail    <= cfg_data[15:0];
        CFG_FRONT_AXLE_DISTANCE: cfg_r.front_axle_distance <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  ftat_front u_front (
    .in_item  (in_data),
    .cfg      (cfg_r),
    .mid_item (mid_wr_item)
  );

  assign mid_wr  = in_push && !mid_full;
  assign in_full = mid_full;

  ftat_queue #(.W($bits(ftat_mid_t)), .DEPTH(4)) u_mid_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (mid_wr_item),
    .rd_en   (mid_pop),
    .rd_data (mid_rd_item),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  ftat_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_item  (mid_rd_item),
    .mid_valid (!mid_empty),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res_item  (res_item)
  );

  ftat_queue #(.W($bits(ftat_out_t)), .DEPTH(2)) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_item),
    .rd_en   (out_pop && !out_empty),
    .rd_data (out_data),
    .full    (res_full),
    .empty   (out_empty)
  );
endmodule
`default_nettype wire
